/* hdl/trie_dictionary_match_scanner_unit_assert.svh */
// Assertion macros shared by the trie dictionary match scanner modules.
// Depends on nothing; each module that checks itself includes this header.
`ifndef TRIE_DICTIONARY_MATCH_SCANNER_UNIT_ASSERT_SVH
`define TRIE_DICTIONARY_MATCH_SCANNER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
// Plain invariant, checked at every edge outside reset
`define TDMS_ASSERT(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
		else $error("tdms assertion failed");
// Same-cycle implication
`define TDMS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("tdms assertion failed");
// Next-cycle implication
`define TDMS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("tdms assertion failed");
`else
`define TDMS_ASSERT(label, clk, rst_n, cond)
`define TDMS_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define TDMS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

/* hdl/tdms_pkg.sv */
// Shared types and constants of the trie dictionary match scanner.
// Used by the controller, the datapath and the top level; depends on nothing.
package tdms_pkg;

	// Default sizes
	localparam int NODES_DEF    = 1024;
	localparam int ALPHABET_DEF = 26;
	localparam int TEXT_MAX_DEF = 128;
	localparam int WORD_MAX_DEF = 64;

	// Operation codes of an input word
	localparam logic [1:0] OP_PATTERN = 2'd0;
	localparam logic [1:0] OP_TEXT    = 2'd1;
	localparam logic [1:0] OP_SCAN    = 2'd2;
	localparam logic [1:0] OP_NONE    = 2'd3;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic take;        // latch the input word, arm a scan
		logic init_root;   // clear the root row after reset
		logic pat_spoil;   // drop a pattern letter
		logic pat_read;    // read the row of the insert cursor
		logic pat_step;    // follow an existing child
		logic pat_link;    // create a child node and link it
		logic pat_newrow;  // write the row of a new node
		logic pat_wend;    // mark an existing node as a word end
		logic text_wr;     // append a text letter
		logic scan_rd;     // read walk node row and text letter
		logic scan_hit;    // record a match, flush the older one
		logic scan_step;   // advance the walk by one letter
		logic scan_fin;    // emit the final result of the scan
	} cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic bad;         // pattern letter out of range or word too deep
		logic child_zero;  // no child for the pattern letter
		logic room;        // node store has a free node
		logic fin;         // latched final-letter flag
		logic hit;         // walk node is a word end
		logic stop;        // walk ends here
		logic pend_valid;  // a match is held back
		logic out_busy;    // output register full and stalled
	} stat_t;

endpackage

/* hdl/tdms_ctrl.sv */
// Controller of the trie dictionary match scanner: sequences each input word.
// Depends on tdms_pkg and the assertion macro header.
`include "trie_dictionary_match_scanner_unit_assert.svh"

module tdms_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic [1:0]        operation,
	output logic              in_ready,
	input  tdms_pkg::stat_t   stat,
	output tdms_pkg::cmd_t    cmd
);

	localparam logic [3:0] S_INIT   = 4'd0;
	localparam logic [3:0] S_IDLE   = 4'd1;
	localparam logic [3:0] S_P_CHK  = 4'd2;
	localparam logic [3:0] S_P_EVAL = 4'd3;
	localparam logic [3:0] S_P_NEW  = 4'd4;
	localparam logic [3:0] S_P_WEND = 4'd5;
	localparam logic [3:0] S_T_WR   = 4'd6;
	localparam logic [3:0] S_S_RD   = 4'd7;
	localparam logic [3:0] S_S_EV   = 4'd8;
	localparam logic [3:0] S_S_FIN  = 4'd9;

	logic [3:0] state_q;
	logic [3:0] state_d;

	assign in_ready = (state_q == S_IDLE);

	// Next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_INIT: begin
				cmd.init_root = 1'b1;
				state_d       = S_IDLE;
			end
			S_IDLE: begin
				if (in_valid) begin
					cmd.take = 1'b1;
					unique case (operation)
						tdms_pkg::OP_PATTERN: state_d = S_P_CHK;
						tdms_pkg::OP_TEXT:    state_d = S_T_WR;
						tdms_pkg::OP_SCAN:    state_d = S_S_RD;
						tdms_pkg::OP_NONE:    state_d = S_IDLE;
					endcase
				end
			end
			S_P_CHK: begin
				if (stat.bad) begin
					cmd.pat_spoil = 1'b1;
					state_d       = S_IDLE;
				end else begin
					cmd.pat_read = 1'b1;
					state_d      = S_P_EVAL;
				end
			end
			S_P_EVAL: begin
				priority if (!stat.child_zero) begin
					cmd.pat_step = 1'b1;
					state_d      = stat.fin ? S_P_WEND : S_IDLE;
				end else if (stat.room) begin
					cmd.pat_link = 1'b1;
					state_d      = S_P_NEW;
				end else begin
					cmd.pat_spoil = 1'b1;
					state_d       = S_IDLE;
				end
			end
			S_P_NEW: begin
				cmd.pat_newrow = 1'b1;
				state_d        = S_IDLE;
			end
			S_P_WEND: begin
				cmd.pat_wend = 1'b1;
				state_d      = S_IDLE;
			end
			S_T_WR: begin
				cmd.text_wr = 1'b1;
				state_d     = S_IDLE;
			end
			S_S_RD: begin
				cmd.scan_rd = 1'b1;
				state_d     = S_S_EV;
			end
			S_S_EV: begin
				// hold while a held-back match cannot leave
				if (!(stat.hit && stat.pend_valid && stat.out_busy)) begin
					cmd.scan_hit = stat.hit;
					if (stat.stop) begin
						state_d = S_S_FIN;
					end else begin
						cmd.scan_step = 1'b1;
						state_d       = S_S_RD;
					end
				end
			end
			S_S_FIN: begin
				if (!stat.out_busy) begin
					cmd.scan_fin = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	`TDMS_ASSERT_NEXT(a_init_once, clk, arst_n, state_q != S_INIT, state_q != S_INIT)
	`TDMS_ASSERT_IMP(a_flush_free, clk, arst_n, cmd.scan_hit && stat.pend_valid, !stat.out_busy)
	`TDMS_ASSERT_IMP(a_fin_free, clk, arst_n, cmd.scan_fin, !stat.out_busy)
	`TDMS_ASSERT_NEXT(a_take_busy, clk, arst_n,
		in_valid && in_ready && operation != tdms_pkg::OP_NONE, state_q != S_IDLE)

endmodule

/* hdl/tdms_dp.sv */
// Datapath of the trie dictionary match scanner: trie rows, text store, result register.
// Depends on tdms_pkg and the assertion macro header; driven by tdms_ctrl.
`include "trie_dictionary_match_scanner_unit_assert.svh"

module tdms_dp #(
	parameter int NODES    = tdms_pkg::NODES_DEF,
	parameter int ALPHABET = tdms_pkg::ALPHABET_DEF,
	parameter int TEXT_MAX = tdms_pkg::TEXT_MAX_DEF,
	parameter int WORD_MAX = tdms_pkg::WORD_MAX_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  tdms_pkg::cmd_t  cmd,
	output tdms_pkg::stat_t stat,
	input  logic [4:0]      letter,
	input  logic            final_letter,
	input  logic [6:0]      start_position,
	output logic            out_valid,
	input  logic            out_ready,
	output logic            found,
	output logic [6:0]      match_start,
	output logic [6:0]      match_end,
	output logic            last_of_run,
	output logic            overflow
);

	localparam int IW    = $clog2(NODES);
	localparam int NUW   = $clog2(NODES + 1);
	localparam int LANES = ALPHABET + 1;
	localparam int LW    = $clog2(LANES);
	localparam int DW    = $clog2(WORD_MAX + 1);
	localparam int TAW   = (TEXT_MAX > 1) ? $clog2(TEXT_MAX) : 1;
	localparam int LEN_W = $clog2(TEXT_MAX + 1);
	localparam int RW    = (LEN_W > 7) ? LEN_W : 7;

	// Trie rows: one child lane per letter, the top lane holds the word-end mark
	logic [LANES-1:0][IW-1:0] trie_mem [NODES];
	logic [4:0]               text_mem [TEXT_MAX];

	logic [LANES-1:0][IW-1:0] row_q;
	logic [4:0]               text_q;

	// Latched input word
	logic [4:0]     letter_q;
	logic           fin_q;
	logic [6:0]     start_q;

	// Insertion and text state
	logic [NUW-1:0]   nodes_used_q;
	logic [IW-1:0]    cursor_q;
	logic [DW-1:0]    depth_q;
	logic [IW-1:0]    nxt_q;
	logic [LEN_W-1:0] len_q;
	logic             closed_q;
	logic             overflow_q;

	// Walk state
	logic [IW-1:0] node_q;
	logic [RW-1:0] r_q;
	logic          pend_valid_q;
	logic [6:0]    pend_end_q;

	// Result register
	logic       out_valid_q;
	logic       out_found_q;
	logic [6:0] out_start_q;
	logic [6:0] out_end_q;
	logic       out_last_q;
	logic       out_ovf_q;

	logic [LW-1:0]            lane_in;
	logic [LW-1:0]            lane_tx;
	logic [IW-1:0]            child_pat;
	logic [IW-1:0]            child_tx;
	logic [IW-1:0]            new_node;
	logic                     bad_letter;
	logic [LANES-1:0][IW-1:0] row_new;
	logic [LEN_W-1:0]         len_eff;
	logic                     text_room;
	logic                     push;

	logic                     we_lane;
	logic                     we_row;
	logic [IW-1:0]            waddr;
	logic [LW-1:0]            wlane;
	logic [IW-1:0]            wdata;
	logic [LANES-1:0][IW-1:0] wrow;
	logic [IW-1:0]            raddr;

	// Child lookup and checks
	assign lane_in    = LW'(letter_q);
	assign lane_tx    = LW'(text_q);
	assign child_pat  = row_q[lane_in];
	assign child_tx   = row_q[lane_tx];
	assign new_node   = IW'(nodes_used_q);
	assign bad_letter = (32'(letter_q) >= ALPHABET) || (depth_q >= DW'(WORD_MAX));
	assign len_eff    = closed_q ? '0 : len_q;
	assign text_room  = (len_eff < LEN_W'(TEXT_MAX));

	always_comb begin
		row_new           = '0;
		row_new[ALPHABET] = IW'(fin_q);
	end

	assign stat.bad        = bad_letter;
	assign stat.child_zero = (child_pat == '0);
	assign stat.room       = (nodes_used_q < NUW'(NODES));
	assign stat.fin        = fin_q;
	assign stat.hit        = row_q[ALPHABET][0];
	assign stat.stop       = (r_q >= RW'(len_q)) || (32'(text_q) >= ALPHABET)
		|| (child_tx == '0);
	assign stat.pend_valid = pend_valid_q;
	assign stat.out_busy   = out_valid_q && !out_ready;

	// Select the trie write
	always_comb begin
		we_lane = 1'b0;
		we_row  = 1'b0;
		waddr   = nxt_q;
		wlane   = LW'(ALPHABET);
		wdata   = IW'(1);
		wrow    = row_new;
		priority if (cmd.init_root) begin
			we_row = 1'b1;
			waddr  = '0;
			wrow   = '0;
		end else if (cmd.pat_link) begin
			we_lane = 1'b1;
			waddr   = cursor_q;
			wlane   = lane_in;
			wdata   = new_node;
		end else if (cmd.pat_newrow) begin
			we_row = 1'b1;
		end else if (cmd.pat_wend) begin
			we_lane = 1'b1;
		end
	end

	assign raddr = cmd.scan_rd ? node_q : cursor_q;

	// Trie row store
	always_ff @(posedge clk) begin
		if (we_row) begin
			trie_mem[waddr] <= wrow;
		end else if (we_lane) begin
			trie_mem[waddr][wlane] <= wdata;
		end
		if (cmd.pat_read || cmd.scan_rd) begin
			row_q <= trie_mem[raddr];
		end
	end

	// Text store
	always_ff @(posedge clk) begin
		if (cmd.text_wr && text_room) begin
			text_mem[TAW'(len_eff)] <= letter_q;
		end
		if (cmd.scan_rd) begin
			text_q <= text_mem[TAW'(r_q)];
		end
	end

	// Latch the input word
	always_ff @(posedge clk) begin
		if (cmd.take) begin
			letter_q <= letter;
			fin_q    <= final_letter;
			start_q  <= start_position;
		end
	end

	// Insertion, text and walk control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nodes_used_q <= NUW'(1);
			cursor_q     <= '0;
			depth_q      <= '0;
			nxt_q        <= '0;
			len_q        <= '0;
			closed_q     <= 1'b1;
			overflow_q   <= 1'b0;
			node_q       <= '0;
			r_q          <= '0;
			pend_valid_q <= 1'b0;
		end else begin
			// drop a spoiled letter; a final letter still returns to the root
			if (cmd.pat_spoil) begin
				overflow_q <= 1'b1;
				cursor_q   <= fin_q ? '0 : cursor_q;
				depth_q    <= fin_q ? '0 : DW'(WORD_MAX);
			end
			if (cmd.pat_step || cmd.pat_link) begin
				nxt_q    <= cmd.pat_link ? new_node : child_pat;
				cursor_q <= fin_q ? '0 : (cmd.pat_link ? new_node : child_pat);
				depth_q  <= fin_q ? '0 : depth_q + DW'(1);
			end
			if (cmd.pat_link) begin
				nodes_used_q <= nodes_used_q + NUW'(1);
			end
			// append a text letter, opening a new text after a closed one
			if (cmd.text_wr) begin
				if (text_room) begin
					len_q <= len_eff + LEN_W'(1);
				end else begin
					len_q      <= len_eff;
					overflow_q <= 1'b1;
				end
				closed_q <= fin_q;
			end
			// arm and advance the walk
			if (cmd.take) begin
				node_q       <= '0;
				r_q          <= RW'(start_position);
				pend_valid_q <= 1'b0;
			end
			if (cmd.scan_hit) begin
				pend_valid_q <= 1'b1;
			end
			if (cmd.scan_step) begin
				node_q <= child_tx;
				r_q    <= r_q + RW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.scan_hit) begin
			pend_end_q <= 7'(r_q - RW'(1));
		end
	end

	// Result register: a match is held back until the next one or the end of the scan, so the last one can be marked
	assign push = (cmd.scan_hit && pend_valid_q) || cmd.scan_fin;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (push) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			out_found_q <= pend_valid_q;
			out_start_q <= start_q;
			out_end_q   <= pend_valid_q ? pend_end_q : '0;
			out_last_q  <= cmd.scan_fin;
			out_ovf_q   <= overflow_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign found       = out_found_q;
	assign match_start = out_start_q;
	assign match_end   = out_end_q;
	assign last_of_run = out_last_q;
	assign overflow    = out_ovf_q;

	`TDMS_ASSERT(a_cursor_live, clk, arst_n, NUW'(cursor_q) < nodes_used_q)
	`TDMS_ASSERT(a_node_live, clk, arst_n, NUW'(node_q) < nodes_used_q)
	`TDMS_ASSERT(a_depth_cap, clk, arst_n, depth_q <= DW'(WORD_MAX))
	`TDMS_ASSERT_NEXT(a_push_shows, clk, arst_n, push, out_valid_q)

endmodule

/* hdl/trie_dictionary_match_scanner_unit.sv */
// Trie dictionary match scanner, top level: controller plus datapath.
// Pattern letter: a range check, a registered row read, then any node writes.
// Text letter: a write into the text store. Scan: each trie step is one registered
// row read; a stalled output holds the walk.
// Reset clears control state and then clears the root row; in_ready stays low
// while it does. Depends on tdms_pkg, tdms_ctrl, tdms_dp.

module trie_dictionary_match_scanner_unit #(
	parameter int NODES    = tdms_pkg::NODES_DEF,
	parameter int ALPHABET = tdms_pkg::ALPHABET_DEF,
	parameter int TEXT_MAX = tdms_pkg::TEXT_MAX_DEF,
	parameter int WORD_MAX = tdms_pkg::WORD_MAX_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] operation,
	input  logic [4:0] letter,
	input  logic       final_letter,
	input  logic [6:0] start_position,
	output logic       out_valid,
	input  logic       out_ready,
	output logic       found,
	output logic [6:0] match_start,
	output logic [6:0] match_end,
	output logic       last_of_run,
	output logic       overflow
);

	tdms_pkg::cmd_t  cmd;
	tdms_pkg::stat_t stat;

	// Sequence each word
	tdms_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.operation (operation),
		.in_ready  (in_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	// Hold the trie, the text and the result register
	tdms_dp #(
		.NODES    (NODES),
		.ALPHABET (ALPHABET),
		.TEXT_MAX (TEXT_MAX),
		.WORD_MAX (WORD_MAX)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.stat           (stat),
		.letter         (letter),
		.final_letter   (final_letter),
		.start_position (start_position),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.found          (found),
		.match_start    (match_start),
		.match_end      (match_end),
		.last_of_run    (last_of_run),
		.overflow       (overflow)
	);

endmodule
